// ===== sv/tlc_pkg.sv =====
// ============================================================================
// tlc_pkg
// Shared widths, register codes, reset values and types of the tripwire
// line crossing counter.
// ============================================================================
package tlc_pkg;

   localparam int COORD_BITS     = 10;
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int PROD_BITS      = 2 * DIFF_BITS;
   localparam int TRACK_ID_W     = 6;
   localparam int TRACK_IDS      = 1 << TRACK_ID_W;
   localparam int COUNT_W        = 16;
   localparam int DEF_MAX_TRACKS = 64;

   localparam int REQ_TDATA_W = 32;  // track_id, point_x, point_y, padded
   localparam int REQ_TUSER_W = 2;   // req_type, first_point
   localparam int RSP_TDATA_W = 24;  // crossed, direction_up, entered_count

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_LINE_Y = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_END_X = 1'b1;

   localparam logic [COORD_BITS-1:0] REF_LINE_Y_RESET = 10'd120;
   localparam logic [COORD_BITS-1:0] LINE_END_X_RESET = 10'd320;
   localparam logic [COUNT_W-1:0]    COUNT_MAX        = 16'hFFFF;

   localparam logic REQ_NEW_TRACK = 1'b0;

   // orientation of an ordered point triple
   localparam logic [1:0] ORI_COL = 2'd0;
   localparam logic [1:0] ORI_CW  = 2'd1;
   localparam logic [1:0] ORI_CCW = 2'd2;

   typedef struct packed {
      logic [COORD_BITS-1:0] ax;  // segment start (older point)
      logic [COORD_BITS-1:0] ay;
      logic [COORD_BITS-1:0] bx;  // segment end (newer point)
      logic [COORD_BITS-1:0] by;
      logic [COORD_BITS-1:0] ly;  // reference line row
      logic [COORD_BITS-1:0] ex;  // reference line right end
   } seg_type;

   typedef struct packed {
      logic    req_pt;   // trace point (else new-track clear)
      logic    test_en;  // a full segment is held and is to be tested
      logic    up;       // segment start lies below the line
      seg_type seg;
   } stage_type;

endpackage

// ===== sv/tlc_seg_test.sv =====
// ============================================================================
// tlc_seg_test
// Two-stage segment against reference line intersection test: products,
// bounding-box compares and the line-based orientations on the first stage,
// the remaining orientation signs and final decision on registered values.
// ============================================================================
module tlc_seg_test (
   input  logic             clock,
   input  logic             adv,     // stage one item moves on
   input  tlc_pkg::seg_type seg,     // stage one segment and line
   output logic             meet     // registered segment meets the line
);
   import tlc_pkg::*;

   localparam int VW = PROD_BITS + 1;

   logic signed [DIFF_BITS-1:0] dy_ab, dx_ab, ly_by, neg_bx, ex_bx;
   logic signed [PROD_BITS-1:0] m1_in, m2_in, m3_in;
   logic [COORD_BITS-1:0]       min_x, max_x, min_y, max_y;
   logic [1:0]                  o3_in, o4_in;
   logic                        w1_in, w2_in, w3_in, w4_in;

   logic signed [PROD_BITS-1:0] m1_ff, m2_ff, m3_ff;
   logic [1:0]                  o3_ff, o4_ff;
   logic                        w1_ff, w2_ff, w3_ff, w4_ff;

   logic [VW-1:0] v1, v2;
   logic [1:0]    o1, o2;

   always_comb begin
      dy_ab  = $signed({1'b0, seg.by}) - $signed({1'b0, seg.ay});
      dx_ab  = $signed({1'b0, seg.bx}) - $signed({1'b0, seg.ax});
      ly_by  = $signed({1'b0, seg.ly}) - $signed({1'b0, seg.by});
      neg_bx = -$signed({1'b0, seg.bx});
      ex_bx  = $signed({1'b0, seg.ex}) - $signed({1'b0, seg.bx});
      m1_in  = dy_ab * neg_bx;
      m2_in  = dy_ab * ex_bx;
      m3_in  = dx_ab * ly_by;

      min_x = (seg.ax < seg.bx) ? seg.ax : seg.bx;
      max_x = (seg.ax < seg.bx) ? seg.bx : seg.ax;
      min_y = (seg.ay < seg.by) ? seg.ay : seg.by;
      max_y = (seg.ay < seg.by) ? seg.by : seg.ay;

      // line as the base: sign of -ex * (p.y - ly)
      if (seg.ex == '0 || seg.ay == seg.ly) begin
         o3_in = ORI_COL;
      end else if (seg.ay < seg.ly) begin
         o3_in = ORI_CW;
      end else begin
         o3_in = ORI_CCW;
      end
      if (seg.ex == '0 || seg.by == seg.ly) begin
         o4_in = ORI_COL;
      end else if (seg.by < seg.ly) begin
         o4_in = ORI_CW;
      end else begin
         o4_in = ORI_CCW;
      end

      w1_in = (min_x == '0) && (seg.ly >= min_y) && (seg.ly <= max_y);
      w2_in = (seg.ex >= min_x) && (seg.ex <= max_x) &&
              (seg.ly >= min_y) && (seg.ly <= max_y);
      w3_in = (seg.ax <= seg.ex) && (seg.ay == seg.ly);
      w4_in = (seg.bx <= seg.ex) && (seg.by == seg.ly);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
         o3_ff <= o3_in;
         o4_ff <= o4_in;
         w1_ff <= w1_in;
         w2_ff <= w2_in;
         w3_ff <= w3_in;
         w4_ff <= w4_in;
      end
   end

   always_comb begin
      v1 = {m1_ff[PROD_BITS-1], m1_ff} - {m3_ff[PROD_BITS-1], m3_ff};
      v2 = {m2_ff[PROD_BITS-1], m2_ff} - {m3_ff[PROD_BITS-1], m3_ff};
      if (v1 == '0) begin
         o1 = ORI_COL;
      end else if (!v1[VW-1]) begin
         o1 = ORI_CW;
      end else begin
         o1 = ORI_CCW;
      end
      if (v2 == '0) begin
         o2 = ORI_COL;
      end else if (!v2[VW-1]) begin
         o2 = ORI_CW;
      end else begin
         o2 = ORI_CCW;
      end
      meet = ((o1 != o2) && (o3_ff != o4_ff)) ||
             ((o1 == ORI_COL) && w1_ff) ||
             ((o2 == ORI_COL) && w2_ff) ||
             ((o3_ff == ORI_COL) && w3_ff) ||
             ((o4_ff == ORI_COL) && w4_ff);
   end

endmodule

// ===== sv/tlc_flag_ram.sv =====
// ============================================================================
// tlc_flag_ram
// Per-track crossed flag memory: one write port, one registered read port,
// forwarding of recent writes, and a clearing sweep after reset.
// ============================================================================
module tlc_flag_ram #(
   parameter int MAX_TRACKS = tlc_pkg::DEF_MAX_TRACKS,
   parameter int AW         = $clog2(MAX_TRACKS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   output logic          rd_flag,     // flag of the item last read
   output logic          clr_busy
);
   import tlc_pkg::*;

   logic flag_mem [MAX_TRACKS];

   logic          rd_data_ff;
   logic [AW-1:0] rd_addr_ff;
   logic          last_v_ff, last_v_in;
   logic [AW-1:0] last_addr_ff;
   logic          last_data_ff;
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         flag_mem[clr_idx_ff] <= 1'b0;
      end else if (wr_en) begin
         flag_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= flag_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en) begin
         last_addr_ff <= wr_addr;
         last_data_ff <= wr_data;
      end
   end

   always_comb begin
      last_v_in   = last_v_ff || wr_en;
      clr_busy_in = clr_busy_ff && (clr_idx_ff != AW'(MAX_TRACKS - 1));
      clr_idx_in  = clr_busy_ff ? clr_idx_ff + AW'(1) : clr_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_v_ff   <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         last_v_ff   <= last_v_in;
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // newest first: the write at this edge, then the last write, then memory
   always_comb begin
      if (wr_en && (wr_addr == rd_addr_ff)) begin
         rd_flag = wr_data;
      end else if (last_v_ff && (last_addr_ff == rd_addr_ff)) begin
         rd_flag = last_data_ff;
      end else begin
         rd_flag = rd_data_ff;
      end
   end

   assign clr_busy = clr_busy_ff;

endmodule

// ===== sv/tripwire_line_crossing_counter_top.sv =====
// ============================================================================
// tripwire_line_crossing_counter_top
// Tests trace segments against a horizontal tripwire, reports the first
// crossing of each track with its direction and counts upward crossings.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------
//  req     | in  | req_tvalid/tready   | tdata: track_id, point_x, point_y
//          |     |                     | tuser: req_type, first_point
//  rsp     | out | rsp_tvalid/tready   | tdata: crossed, direction_up,
//          |     |                     |        entered_count
//  csr     | in  | csr_valid/ready     | csr_index, csr_data
//
// One item per cycle while rsp is not stalled; a result passes stage one
// (flag read and products), stage two (decision and flag write) and then
// the output register. After reset all MAX_TRACKS flag memory entries are
// swept clear, during which req_tready is low. A stalled rsp holds the
// pipeline; req_tready stays high while the stage one slot can move on.
// ============================================================================
module tripwire_line_crossing_counter_top #(
   parameter int MAX_TRACKS = tlc_pkg::DEF_MAX_TRACKS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [5:0] track_id, [15:6] point_x, [25:16] point_y, [31:26] zero
   input  logic [tlc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] req_type, [1] first_point
   input  logic [tlc_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] crossed, [1] direction_up, [17:2] entered_count, [23:18] zero
   output logic [tlc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tlc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tlc_pkg::COORD_BITS-1:0]     csr_data
);
   import tlc_pkg::*;

   localparam int AW = $clog2(MAX_TRACKS);

   // input fields
   logic                  in_req_type, in_first;
   logic [TRACK_ID_W-1:0] in_tid;
   logic [COORD_BITS-1:0] in_x, in_y;
   logic [AW-1:0]         tid_lut [TRACK_IDS];
   logic [AW-1:0]         in_addr;

   // configuration
   logic [COORD_BITS-1:0] ref_line_y_ff, line_end_x_ff;

   // point history
   logic [COORD_BITS-1:0] older_x_ff, older_y_ff, newer_x_ff, newer_y_ff;
   logic [1:0]            points_seen_ff, points_seen_in;

   // pipeline
   logic          req_fire, adv1, adv2;
   logic          s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   stage_type     s1_ff, s1_in;
   logic [AW-1:0] s1_addr_ff, s2_addr_ff;
   logic          s2_req_pt_ff, s2_test_en_ff, s2_up_ff, s2_flag_ff;
   logic          meet, s2_hit, wr_en;
   logic          rd_flag, clr_busy;

   logic [COUNT_W-1:0] entry_total_ff, entry_total_in;
   logic               rsp_v_ff, rsp_v_in;
   logic               rsp_crossed_ff, rsp_dir_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // track id wraps modulo MAX_TRACKS
   for (genvar g = 0; g < TRACK_IDS; g++) begin : g_tid
      assign tid_lut[g] = AW'(g % MAX_TRACKS);
   end

   always_comb begin
      in_tid      = req_tdata[TRACK_ID_W-1:0];
      in_x        = req_tdata[TRACK_ID_W +: COORD_BITS];
      in_y        = req_tdata[TRACK_ID_W + COORD_BITS +: COORD_BITS];
      in_req_type = req_tuser[0];
      in_first    = req_tuser[1];
      in_addr     = tid_lut[in_tid];
   end

   // handshakes and stage advance
   always_comb begin
      adv2       = s2_v_ff && (!rsp_v_ff || rsp_tready);
      adv1       = s1_v_ff && (!s2_v_ff || adv2);
      req_tready = !clr_busy && (!s1_v_ff || adv1);
      req_fire   = req_tvalid && req_tready;
      csr_ready  = 1'b1;
      s1_v_in    = req_fire || (s1_v_ff && !adv1);
      s2_v_in    = adv1 || (s2_v_ff && !adv2);
      rsp_v_in   = adv2 || (rsp_v_ff && !rsp_tready);
   end

   // stage one load and history advance
   always_comb begin
      s1_in.req_pt  = (in_req_type != REQ_NEW_TRACK);
      s1_in.test_en = s1_in.req_pt && !in_first && (points_seen_ff == 2'd2);
      s1_in.up      = (older_y_ff > ref_line_y_ff);
      s1_in.seg.ax  = older_x_ff;
      s1_in.seg.ay  = older_y_ff;
      s1_in.seg.bx  = newer_x_ff;
      s1_in.seg.by  = newer_y_ff;
      s1_in.seg.ly  = ref_line_y_ff;
      s1_in.seg.ex  = line_end_x_ff;
      if (in_first) begin
         points_seen_in = 2'd1;
      end else if (points_seen_ff != 2'd2) begin
         points_seen_in = points_seen_ff + 2'd1;
      end else begin
         points_seen_in = points_seen_ff;
      end
   end

   // stage two decision
   always_comb begin
      s2_hit = s2_test_en_ff && !s2_flag_ff && meet;
      wr_en  = adv2 && (!s2_req_pt_ff || s2_hit);
      if (adv2 && s2_hit && s2_up_ff && (entry_total_ff != COUNT_MAX)) begin
         entry_total_in = entry_total_ff + COUNT_W'(1);
      end else begin
         entry_total_in = entry_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_line_y_ff  <= REF_LINE_Y_RESET;
         line_end_x_ff  <= LINE_END_X_RESET;
         older_x_ff     <= '0;
         older_y_ff     <= '0;
         newer_x_ff     <= '0;
         newer_y_ff     <= '0;
         points_seen_ff <= '0;
         entry_total_ff <= '0;
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         rsp_v_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REF_LINE_Y: ref_line_y_ff <= csr_data;
               CSR_LINE_END_X: line_end_x_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_fire && s1_in.req_pt) begin
            older_x_ff     <= newer_x_ff;
            older_y_ff     <= newer_y_ff;
            newer_x_ff     <= in_x;
            newer_y_ff     <= in_y;
            points_seen_ff <= points_seen_in;
         end
         entry_total_ff <= entry_total_in;
         s1_v_ff        <= s1_v_in;
         s2_v_ff        <= s2_v_in;
         rsp_v_ff       <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff      <= s1_in;
         s1_addr_ff <= in_addr;
      end
      if (adv1) begin
         s2_addr_ff    <= s1_addr_ff;
         s2_req_pt_ff  <= s1_ff.req_pt;
         s2_test_en_ff <= s1_ff.test_en;
         s2_up_ff      <= s1_ff.up;
         s2_flag_ff    <= rd_flag;
      end
      if (adv2) begin
         rsp_crossed_ff <= s2_hit;
         rsp_dir_ff     <= s2_hit && s2_up_ff;
         rsp_count_ff   <= entry_total_in;
      end
   end

   tlc_flag_ram #(
      .MAX_TRACKS (MAX_TRACKS),
      .AW         (AW)
   ) u_flag_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (in_addr),
      .wr_en    (wr_en),
      .wr_addr  (s2_addr_ff),
      .wr_data  (s2_req_pt_ff),
      .rd_flag  (rd_flag),
      .clr_busy (clr_busy)
   );

   tlc_seg_test u_seg_test (
      .clock (clock),
      .adv   (adv1),
      .seg   (s1_ff.seg),
      .meet  (meet)
   );

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - COUNT_W - 2)'(0), rsp_count_ff,
                        rsp_dir_ff, rsp_crossed_ff};

   a_no_accept_while_clearing : assert property (
      @(posedge clock) disable iff (reset) clr_busy |-> !req_tready)
      else $error("item accepted during flag clearing sweep");

   a_count_never_drops : assert property (
      @(posedge clock) disable iff (reset)
      !$past(reset) |-> entry_total_ff >= $past(entry_total_ff))
      else $error("entry count decreased");

   a_count_step_one : assert property (
      @(posedge clock) disable iff (reset)
      !$past(reset) |-> (entry_total_ff - $past(entry_total_ff)) <= COUNT_W'(1))
      else $error("entry count jumped by more than one");

   a_dir_needs_cross : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_dir_ff) |-> rsp_crossed_ff)
      else $error("direction reported without a crossing");

endmodule
